[hdl/pli_pkg.sv]
//------------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
//------------------------------------------------------------------------------
package pli_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = 4;
   localparam int CNT_W = 5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_COUNT = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_TABLE = 2'd3;

   localparam logic signed [31:0] ERR_VALUE = -32'sd65536;

   localparam logic [1:0] CSR_MIN_VOLTAGE = 2'd0;
   localparam logic [1:0] CSR_MAX_VOLTAGE = 2'd1;
   localparam logic [1:0] CSR_X_COUNT     = 2'd2;
   localparam logic [1:0] CSR_Y_COUNT     = 2'd3;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic               command;
      logic [3:0]         entry_index;
      logic signed [15:0] entry_x;
      logic signed [31:0] entry_y;
      logic signed [15:0] query_x;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] interpolated_value;
   } rsp_type;

   // classified job handed from front to back
   typedef struct packed {
      logic               done;      // result already known
      logic               is_write;  // table write carried to the back
      logic [IDX_W-1:0]   entry_index;
      logic signed [15:0] entry_x;
      logic signed [31:0] entry_y;
      logic [1:0]         status;
      logic signed [31:0] value;
      logic signed [15:0] query_x;
      logic [CNT_W-1:0]   count;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_READ, BK_SCAN, BK_FETCH, BK_DIFF, BK_MUL, BK_DIV, BK_DONE
   } back_state_type;

endpackage

[hdl/pli_front.sv]
//------------------------------------------------------------------------------
// pli_front
// Accepts commands and classifies them into jobs for the back.
//------------------------------------------------------------------------------
module pli_front (
   input  logic                    take,
   input  pli_pkg::req_type        req,
   input  logic signed [15:0]      min_voltage,
   input  logic signed [15:0]      max_voltage,
   input  logic [4:0]              x_count,
   input  logic [4:0]              y_count,
   output logic                    job_valid,
   output pli_pkg::job_type        job
);
   logic [4:0] n;

   always_comb begin
      n = (x_count > 5'(pli_pkg::TABLE_DEPTH)) ? 5'(pli_pkg::TABLE_DEPTH) : x_count;
      job.query_x     = req.query_x;
      job.count       = n;
      job.is_write    = req.command == pli_pkg::CMD_WRITE;
      job.entry_index = req.entry_index;
      job.entry_x     = req.entry_x;
      job.entry_y     = req.entry_y;
      job.done        = 1'b1;
      job.status      = pli_pkg::ST_OK;
      job.value       = '0;
      if (req.command == pli_pkg::CMD_QUERY) begin
         if (x_count != y_count) begin
            job.status = pli_pkg::ST_COUNT;
            job.value  = pli_pkg::ERR_VALUE;
         end else if (req.query_x <= min_voltage || req.query_x >= max_voltage) begin
            job.status = pli_pkg::ST_RANGE;
            job.value  = pli_pkg::ERR_VALUE;
         end else if (n < 5'd2) begin
            job.status = pli_pkg::ST_TABLE;
            job.value  = pli_pkg::ERR_VALUE;
         end else begin
            job.done = 1'b0;
         end
      end
   end

   assign job_valid = take;
endmodule

[hdl/pli_queue.sv]
//------------------------------------------------------------------------------
// pli_queue
// Two-entry queue of jobs between the front and the back.
//------------------------------------------------------------------------------
module pli_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pli_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output pli_pkg::job_type head
);
   pli_pkg::job_type mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign head  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

[hdl/pli_back.sv]
//------------------------------------------------------------------------------
// pli_back
// Holds the breakpoint table, applies writes in order, scans it and
// interpolates with a serial divider.
//------------------------------------------------------------------------------
module pli_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_ready,
   input  pli_pkg::job_type    job,
   output logic                job_pop,
   output logic                rsp_strobe,
   output pli_pkg::rsp_type    rsp
);
   logic signed [15:0] bx_mem [pli_pkg::TABLE_DEPTH];
   logic signed [31:0] by_mem [pli_pkg::TABLE_DEPTH];

   pli_pkg::back_state_type state_ff, state_in;
   logic signed [15:0]      qx_ff;
   logic [4:0]              cnt_ff;
   logic [4:0]              idx_ff;
   logic signed [15:0]      rx_ff, x2_ff;
   logic signed [31:0]      ry_ff, y1_ff, y2_ff;
   logic [15:0]             qd_ff, dx_ff;
   logic signed [32:0]      dy_ff;
   logic [15:0]             rem_ff;
   logic [31:0]             quo_ff;   // dividend low bits, shifted out as quotient fills
   logic                    neg_ff;
   logic [4:0]              bit_ff;
   logic [1:0]              ost_ff;
   logic signed [31:0]      oval_ff;
   logic                    ostb_ff;

   logic [3:0]  rd_addr;
   logic        tbl_we;
   logic        below;
   logic [31:0] dy_mag;
   logic [47:0] prod;
   logic [16:0] rem_sh;
   logic [16:0] rem_sub;
   logic        q_bit;
   logic [15:0] rem_next;
   logic [31:0] quo_next;

   assign rd_addr = idx_ff[3:0];
   assign tbl_we  = state_ff == pli_pkg::BK_IDLE && job_ready && job.is_write;
   assign below   = qx_ff < rx_ff;

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         bx_mem[job.entry_index] <= job.entry_x;
         by_mem[job.entry_index] <= job.entry_y;
      end
      rx_ff <= bx_mem[rd_addr];
      ry_ff <= by_mem[rd_addr];
   end

   // quotient is known to fit 32 bits, so only 32 restoring steps are needed
   assign dy_mag   = dy_ff[32] ? 32'(-dy_ff) : dy_ff[31:0];
   assign prod     = 48'(qd_ff) * 48'(dy_mag);
   assign rem_sh   = {rem_ff, quo_ff[31]};
   assign rem_sub  = rem_sh - {1'b0, dx_ff};
   assign q_bit    = !rem_sub[16];
   assign rem_next = q_bit ? rem_sub[15:0] : rem_sh[15:0];
   assign quo_next = {quo_ff[30:0], q_bit};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pli_pkg::BK_IDLE:  if (job_ready) state_in = job.done ? pli_pkg::BK_DONE
                                                             : pli_pkg::BK_READ;
         pli_pkg::BK_READ:  state_in = pli_pkg::BK_SCAN;
         pli_pkg::BK_SCAN:
            if (below) state_in = (idx_ff == 5'd0) ? pli_pkg::BK_DONE : pli_pkg::BK_FETCH;
            else if (idx_ff + 5'd1 >= cnt_ff) state_in = pli_pkg::BK_DONE;
            else state_in = pli_pkg::BK_READ;
         pli_pkg::BK_FETCH: state_in = pli_pkg::BK_DIFF;
         pli_pkg::BK_DIFF:  state_in = pli_pkg::BK_MUL;
         pli_pkg::BK_MUL:   state_in = pli_pkg::BK_DIV;
         pli_pkg::BK_DIV:   if (bit_ff == 5'd0) state_in = pli_pkg::BK_DONE;
         pli_pkg::BK_DONE:  state_in = pli_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      job_pop = state_ff == pli_pkg::BK_IDLE && job_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pli_pkg::BK_IDLE;
         ostb_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ostb_ff  <= 1'b0;
         unique case (state_ff)
            pli_pkg::BK_IDLE: if (job_ready) begin
               qx_ff   <= job.query_x;
               cnt_ff  <= job.count;
               idx_ff  <= 5'd0;
               ost_ff  <= job.status;
               oval_ff <= job.value;
            end
            pli_pkg::BK_READ: ;
            pli_pkg::BK_SCAN:
               if (below) begin
                  if (idx_ff == 5'd0) begin
                     ost_ff <= pli_pkg::ST_TABLE; oval_ff <= pli_pkg::ERR_VALUE;
                  end else begin
                     x2_ff  <= rx_ff; y2_ff <= ry_ff;
                     idx_ff <= idx_ff - 5'd1;
                  end
               end else if (idx_ff + 5'd1 >= cnt_ff) begin
                  ost_ff <= pli_pkg::ST_TABLE; oval_ff <= pli_pkg::ERR_VALUE;
               end else begin
                  idx_ff <= idx_ff + 5'd1;
               end
            pli_pkg::BK_FETCH: ;
            pli_pkg::BK_DIFF: begin
               y1_ff <= ry_ff;
               dx_ff <= 16'(17'(x2_ff) - 17'(rx_ff));
               qd_ff <= 16'(17'(qx_ff) - 17'(rx_ff));
               dy_ff <= 33'(y2_ff) - 33'(ry_ff);
            end
            pli_pkg::BK_MUL: begin
               rem_ff <= prod[47:32];
               quo_ff <= prod[31:0];
               neg_ff <= dy_ff[32];
               bit_ff <= 5'd31;
            end
            pli_pkg::BK_DIV: begin
               rem_ff <= rem_next;
               quo_ff <= quo_next;
               bit_ff <= bit_ff - 5'd1;
               if (bit_ff == 5'd0) begin
                  ost_ff  <= pli_pkg::ST_OK;
                  oval_ff <= neg_ff ? y1_ff - $signed(quo_next) : y1_ff + $signed(quo_next);
               end
            end
            pli_pkg::BK_DONE: ostb_ff <= 1'b1;
         endcase
      end
   end

   assign rsp_strobe = ostb_ff;
   assign rsp.status = ost_ff;
   assign rsp.interpolated_value = oval_ff;
endmodule

[hdl/piecewise_linear_interpolator_core.sv]
//------------------------------------------------------------------------------
// piecewise_linear_interpolator_core
// Breakpoint table lookup with linear interpolation.
//------------------------------------------------------------------------------
// Pulse start with a req_ payload while busy is low. Command write stores one
// breakpoint pair; command query interpolates query_x over the table.
// Each transaction gives one result on rsp_ ports for one cycle, marked by
// rsp_strobe; the receiver cannot stall.
// The front classifies a transaction in its accept cycle and pushes a job
// into a two-entry queue; busy is high while that queue is full.
// The back applies table writes in order, scans the table one entry at a
// time through a read and a scan state (registered read), then divides one
// quotient bit per cycle over 32. Writes and early errors go straight from
// the queue to a result; a query scans up to the first breakpoint above it
// or the table's end, and only an interpolated query goes on to the divider.
// The back takes the next job in the result cycle.
// Configuration is written on the csr_ channel, always ready.
// Reset is synchronous; table contents are undefined until written.
//------------------------------------------------------------------------------
module piecewise_linear_interpolator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pli_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output pli_pkg::rsp_type rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   logic signed [15:0] min_ff, max_ff;
   logic [4:0]         xc_ff, yc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 16'sh8000; max_ff <= 16'sh7fff; xc_ff <= '0; yc_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pli_pkg::CSR_MIN_VOLTAGE: min_ff <= csr_data[15:0];
            pli_pkg::CSR_MAX_VOLTAGE: max_ff <= csr_data[15:0];
            pli_pkg::CSR_X_COUNT:     xc_ff  <= csr_data[4:0];
            pli_pkg::CSR_Y_COUNT:     yc_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   logic take, jv, full, empty, pop;
   pli_pkg::job_type fj, hj;

   assign busy = full;
   assign take = start && !busy;

   pli_front u_front (.take, .req(req_payload),
      .min_voltage(min_ff), .max_voltage(max_ff), .x_count(xc_ff), .y_count(yc_ff),
      .job_valid(jv), .job(fj));

   pli_queue u_queue (.clock, .reset, .push(jv), .push_job(fj), .pop,
      .full, .empty, .head(hj));

   pli_back u_back (.clock, .reset,
      .job_ready(!empty), .job(hj), .job_pop(pop), .rsp_strobe, .rsp(rsp_payload));
endmodule

[dv/piecewise_linear_interpolator_core_tb.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// piecewise_linear_interpolator_core_tb
// Drives write and query transactions through phases of limit and count
// settings, predicts every result from a local table copy and checks each one.
//------------------------------------------------------------------------------
module piecewise_linear_interpolator_core_tb;

   localparam int CYCLE_LIMIT = 1500000;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   pli_pkg::req_type req_payload;
   logic             rsp_strobe;
   pli_pkg::rsp_type rsp_payload;
   logic             csr_valid;
   logic             csr_ready;
   logic [1:0]       csr_index;
   logic [31:0]      csr_data;

   piecewise_linear_interpolator_core u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // local copy of the block's table and registers
   logic signed [15:0] bp_x [pli_pkg::TABLE_DEPTH];
   logic signed [31:0] bp_y [pli_pkg::TABLE_DEPTH];
   logic signed [15:0] lim_min, lim_max;
   logic [4:0]         cnt_x, cnt_y;

   pli_pkg::req_type pending_reqs[$];
   pli_pkg::rsp_type expected_rsps[$];
   int      errors = 0;
   int      cycles = 0;
   int      n_writes = 0, n_queries = 0, n_phases = 0;
   int      st_seen [4];
   bit      quiet = 0;
   int      gap = 0;

   function automatic pli_pkg::rsp_type interpolate(pli_pkg::req_type r);
      pli_pkg::rsp_type o;
      int n, k;
      logic signed [63:0] num, den, res;
      o.status = pli_pkg::ST_OK;
      o.interpolated_value = '0;
      if (r.command == pli_pkg::CMD_WRITE) begin
         bp_x[r.entry_index] = r.entry_x;
         bp_y[r.entry_index] = r.entry_y;
         return o;
      end
      o.interpolated_value = pli_pkg::ERR_VALUE;
      if (cnt_x != cnt_y) begin
         o.status = pli_pkg::ST_COUNT;
         return o;
      end
      if (r.query_x <= lim_min || r.query_x >= lim_max) begin
         o.status = pli_pkg::ST_RANGE;
         return o;
      end
      n = (cnt_x > pli_pkg::TABLE_DEPTH) ? pli_pkg::TABLE_DEPTH : cnt_x;
      k = 0;
      for (int j = 0; j < n; j++) begin
         if (r.query_x >= bp_x[j]) k++;
         else break;
      end
      if (k == 0 || k >= n) begin
         o.status = pli_pkg::ST_TABLE;
         return o;
      end
      num = (64'(r.query_x) - 64'(bp_x[k-1])) * (64'(bp_y[k]) - 64'(bp_y[k-1]));
      den = 64'(bp_x[k]) - 64'(bp_x[k-1]);
      res = 64'(bp_y[k-1]) + num / den;
      o.interpolated_value = res[31:0];
      return o;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("piecewise_linear_interpolator_core_tb failed");
         $finish;
      end
   end

   // driver: start rises at a falling edge and is accepted at a rising edge while busy is low
   always @(negedge clock) begin
      if (reset) begin
         start <= 0;
      end else if (start && busy) begin
         // hold the transaction until accepted
      end else if (gap > 0) begin
         start <= 0;
         gap <= gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req_payload <= pending_reqs.pop_front();
         start <= 1;
         if (!quiet && $urandom_range(0, 5) == 0) gap <= $urandom_range(1, 14);
      end else begin
         start <= 0;
      end
   end

   // predict at acceptance so table writes are ordered with queries
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.push_back(interpolate(req_payload));
         if (req_payload.command == pli_pkg::CMD_WRITE) n_writes++;
         else n_queries++;
      end
   end

   // monitor
   always @(posedge clock) begin
      pli_pkg::rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected result status=%0d value=%0d", $time,
                     rsp_payload.status, rsp_payload.interpolated_value);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            st_seen[e.status]++;
            if (e.status != rsp_payload.status)
               begin
                  $display("%0t status expected %0d actual %0d", $time, e.status,
                           rsp_payload.status);
                  errors++;
               end
            if (e.interpolated_value != rsp_payload.interpolated_value) begin
               $display("%0t value expected %0d actual %0d", $time,
                        e.interpolated_value, rsp_payload.interpolated_value);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pli_pkg::CSR_MIN_VOLTAGE: lim_min = val[15:0];
         pli_pkg::CSR_MAX_VOLTAGE: lim_max = val[15:0];
         pli_pkg::CSR_X_COUNT:     cnt_x = val[4:0];
         default:                  cnt_y = val[4:0];
      endcase
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_limits(input int lo, input int hi, input int nx, input int ny);
      wait_drained();
      write_reg(pli_pkg::CSR_MIN_VOLTAGE, 32'(lo));
      write_reg(pli_pkg::CSR_MAX_VOLTAGE, 32'(hi));
      write_reg(pli_pkg::CSR_X_COUNT, 32'(nx));
      write_reg(pli_pkg::CSR_Y_COUNT, 32'(ny));
      n_phases++;
   endtask

   function automatic pli_pkg::req_type make_write(int idx, int x, int y);
      pli_pkg::req_type r;
      r = '0;
      r.command = pli_pkg::CMD_WRITE;
      r.entry_index = idx[3:0];
      r.entry_x = x[15:0];
      r.entry_y = y;
      r.query_x = 16'($urandom);
      return r;
   endfunction

   function automatic pli_pkg::req_type make_query(int q);
      pli_pkg::req_type r;
      r = '0;
      r.command = pli_pkg::CMD_QUERY;
      r.entry_index = 4'($urandom);
      r.entry_x = 16'($urandom);
      r.entry_y = $urandom;
      r.query_x = q[15:0];
      return r;
   endfunction

   // fill the table with a sorted set of breakpoints spanning lo..hi
   task automatic load_table(input int lo, input int hi);
      int span, x;
      span = (hi - lo) / pli_pkg::TABLE_DEPTH;
      if (span < 1) span = 1;
      for (int i = 0; i < pli_pkg::TABLE_DEPTH; i++) begin
         x = lo + i * span + $urandom_range(0, span - 1);
         pending_reqs.push_back(make_write(i, x, int'($urandom)));
      end
   endtask

   initial begin
      int lo, hi, nx;
      start = 0;
      req_payload = '0;
      csr_valid = 0;
      csr_index = pli_pkg::CSR_MIN_VOLTAGE;
      csr_data = '0;
      lim_min = -32768;
      lim_max = 32767;
      cnt_x = 0;
      cnt_y = 0;
      foreach (bp_x[i]) begin
         bp_x[i] = 0;
         bp_y[i] = 0;
      end
      reset = 1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: reset counts (zero) give outside-table, extremes of range
      pending_reqs.push_back(make_query(0));
      pending_reqs.push_back(make_query(-32768));
      pending_reqs.push_back(make_query(32767));
      // extreme table: full-scale x and y steps
      pending_reqs.push_back(make_write(0, -32768, 32'h8000_0000));
      pending_reqs.push_back(make_write(1, 0, 32'h7fff_ffff));
      pending_reqs.push_back(make_write(2, 1, 0));
      pending_reqs.push_back(make_write(3, 32767, -1));
      set_limits(-32768, 32767, 4, 4);
      pending_reqs.push_back(make_query(-32767));
      pending_reqs.push_back(make_query(-1));
      pending_reqs.push_back(make_query(0));
      pending_reqs.push_back(make_query(1));
      pending_reqs.push_back(make_query(32766));
      pending_reqs.push_back(make_query(-32768));
      pending_reqs.push_back(make_query(32767));
      // non-ascending table: a later x below an earlier one
      pending_reqs.push_back(make_write(2, -5, 100));
      pending_reqs.push_back(make_query(10));
      pending_reqs.push_back(make_query(-3));
      // count mismatch, count one, count above depth
      set_limits(-100, 100, 4, 3);
      pending_reqs.push_back(make_query(0));
      pending_reqs.push_back(make_query(500));
      set_limits(32767, -32768, 1, 1);
      pending_reqs.push_back(make_query(0));
      load_table(-32768, 32767);
      set_limits(-32768, 32767, 20, 20);
      pending_reqs.push_back(make_query(0));
      pending_reqs.push_back(make_query(-32000));
      set_limits(-32768, 32767, 31, 31);
      pending_reqs.push_back(make_query(1000));

      // random phases: sorted tables with mostly in-table queries
      for (int ph = 0; ph < 24; ph++) begin
         lo = $urandom_range(0, 3) == 0 ? -32768 : $urandom_range(0, 20000) - 32768;
         hi = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(0, 30000) + 2767;
         if (ph % 8 == 7) hi = lo + $urandom_range(20, 200);
         if (hi > 32767) hi = 32767;
         load_table(lo, hi);
         nx = $urandom_range(0, 4) == 0 ? $urandom_range(0, 31) : $urandom_range(2, 16);
         if (ph == 23) quiet = 1;
         set_limits($urandom_range(0, 3) == 0 ? lo - 1 : lo + $urandom_range(0, 50),
                    $urandom_range(0, 3) == 0 ? hi + 1 : hi - $urandom_range(0, 50),
                    nx, $urandom_range(0, 6) == 0 ? $urandom_range(0, 31) : nx);
         for (int i = 0; i < 30; i++) begin
            case ($urandom_range(0, 9))
               0: pending_reqs.push_back(make_query(int'($urandom_range(0, 65535)) - 32768));
               1: pending_reqs.push_back(make_write(
                     $urandom_range(0, 15), $urandom, $urandom));
               default: pending_reqs.push_back(make_query(lo + int'($urandom_range(0, hi - lo))));
            endcase
         end
      end
      wait_drained();
      $display("covered %0d writes, %0d queries over %0d register phases",
               n_writes, n_queries, n_phases);
      $display("status ok %0d, count %0d, range %0d, table %0d",
               st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
      if (errors == 0) begin
         $display("piecewise_linear_interpolator_core_tb passed");
      end else begin
         $display("piecewise_linear_interpolator_core_tb failed");
      end
      $finish;
   end

endmodule

[piecewise_linear_interpolator_core.f]
hdl/pli_pkg.sv
hdl/pli_front.sv
hdl/pli_queue.sv
hdl/pli_back.sv
hdl/piecewise_linear_interpolator_core.sv
dv/piecewise_linear_interpolator_core_tb.sv
